### hdl/ifmt_pkg.sv
`default_nettype none

package ifmt_pkg;

  localparam int VALUE_W = 64;
  localparam int BCD_DIGITS = 20;
  localparam int BCD_W = 4 * BCD_DIGITS;
  localparam int IN_W = 88;

  // conversion codes
  localparam logic [2:0] CONV_SDEC = 3'd0;
  localparam logic [2:0] CONV_UDEC = 3'd1;
  localparam logic [2:0] CONV_LHEX = 3'd2;
  localparam logic [2:0] CONV_UHEX = 3'd3;
  localparam logic [2:0] CONV_OCT  = 3'd4;

  // operand size codes
  localparam logic [1:0] WS_8  = 2'd0;
  localparam logic [1:0] WS_16 = 2'd1;
  localparam logic [1:0] WS_32 = 2'd2;
  localparam logic [1:0] WS_64 = 2'd3;

  localparam logic [VALUE_W-1:0] MASK_8  = 64'h0000_0000_0000_00ff;
  localparam logic [VALUE_W-1:0] MASK_16 = 64'h0000_0000_0000_ffff;
  localparam logic [VALUE_W-1:0] MASK_32 = 64'h0000_0000_ffff_ffff;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_BLANK = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  // offsets from the character after '9' to 'A' and to 'a'
  localparam logic [7:0] HEX_UPPER_ADD = 8'd7;
  localparam logic [7:0] HEX_LOWER_ADD = 8'd39;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CONV  = 6'b000010,
    S_DIGIT = 6'b000100,
    S_OCT   = 6'b001000,
    S_PLAN  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

endpackage

`default_nettype wire

### hdl/ifmt_ram.sv
`default_nettype none

module ifmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hdl/integer_text_formatter.sv
`default_nettype none

// channel  dir  width        contents
// s_*      in   88 + hs      one integer with its format
// m_*      out  8 + last     one character of the formatted text per transfer
//
// decimal conversions first run shift-and-adjust binary to bcd (none for hex or octal); then
// each digit is written to the digit memory, followed by a stop step, the octal leading zero
// step, planning, the output characters one at a time with a drain of the emit pipeline, and
// the idle state that takes the next item. s_tready is high only while idle; stalls on m_*
// hold the emit pipeline. rst clears the control state; the digit memory needs no clearing.

module integer_text_formatter #(
  parameter int MAX_CHARS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // value[63:0] word_size[65:64] conversion[68:66] field_width[75:69]
  // min_digits[81:76] alt_form[82] force_plus[83] space_sign[84]
  // left_align[85] zero_pad[86] zero[87]
  input  logic [ifmt_pkg::IN_W-1:0]   s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // out_char[7:0]
  output logic [7:0]                  m_tdata,
  output logic                        m_tlast
);

  import ifmt_pkg::*;

  localparam int NW = $clog2(MAX_CHARS + 1);
  localparam int BW = NW + 1;
  localparam int AW = $clog2(MAX_CHARS);

  state_t state;

  // input fields
  logic [VALUE_W-1:0] in_value;
  logic [1:0]         in_ws;
  logic [2:0]         in_conv;
  logic [6:0]         in_width;
  logic [5:0]         in_prec;
  logic               in_alt, in_plus, in_space, in_left, in_zpad;
  logic               in_neg, in_hex, in_upper;
  logic [VALUE_W-1:0] in_mag, in_masked;
  logic [NW-1:0]      in_prec_eff, in_width_eff;
  logic [1:0]         in_plen;
  logic [7:0]         in_pfx0, in_pfx1;
  logic               accept;

  // item registers
  logic          is_oct, upper, left, zpad;
  logic [NW-1:0] prec, width_sat, nd;
  logic [1:0]    plen;
  logic [7:0]    pfx0, pfx1;
  logic [VALUE_W-1:0] sh;
  logic [BCD_W-1:0]   work, bcd_next;
  logic [5:0]    dd_cnt;
  logic          last_nz;

  // digit stage
  logic [3:0] dig;
  logic [7:0] dig_char;
  logic       more;

  // plan and emit
  logic [BW-1:0] used, pad, lp, zp, b1, b2, b3, b4, total, k, sum_all, rd_idx;
  logic [BW-1:0] b1_n, b2_n, b3_n, b4_n;
  logic       issue, advance_out, p1_move;
  logic       p1_v, p1_ram, p1_last;
  logic [7:0] p1_char, sel_char;
  logic       sel_ram;

  // digit memory
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata, ram_rdata;

  assign in_value = s_tdata[63:0];
  assign in_ws    = s_tdata[65:64];
  assign in_conv  = s_tdata[68:66];
  assign in_width = s_tdata[75:69];
  assign in_prec  = s_tdata[81:76];
  assign in_alt   = s_tdata[82];
  assign in_plus  = s_tdata[83];
  assign in_space = s_tdata[84];
  assign in_left  = s_tdata[85];
  assign in_zpad  = s_tdata[86];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    in_neg   = (in_conv == CONV_SDEC) && in_value[VALUE_W-1];
    in_hex   = (in_conv == CONV_LHEX) || (in_conv == CONV_UHEX);
    in_upper = (in_conv == CONV_UHEX);
    in_mag   = in_neg ? (VALUE_W'(0) - in_value) : in_value;
    case (in_ws)
      WS_8:    in_masked = in_mag & MASK_8;
      WS_16:   in_masked = in_mag & MASK_16;
      WS_32:   in_masked = in_mag & MASK_32;
      WS_64:   in_masked = in_mag;
      default: in_masked = in_mag;
    endcase

    if (in_prec == 6'd0) begin
      in_prec_eff = NW'(1);
    end else if (int'(in_prec) > MAX_CHARS - 2) begin
      in_prec_eff = NW'(MAX_CHARS - 2);
    end else begin
      in_prec_eff = NW'(in_prec);
    end
    if (int'(in_width) > MAX_CHARS) begin
      in_width_eff = NW'(MAX_CHARS);
    end else begin
      in_width_eff = NW'(in_width);
    end

    // a sign prefix replaces the 0x prefix
    in_plen = 2'd0;
    in_pfx0 = CH_ZERO;
    in_pfx1 = in_upper ? CH_UX : CH_LX;
    if (in_hex && in_alt && (in_masked != '0)) begin
      in_plen = 2'd2;
    end
    if (in_conv != CONV_UDEC) begin
      if (in_neg) begin
        in_pfx0 = CH_MINUS;
        in_plen = 2'd1;
      end else if (in_plus) begin
        in_pfx0 = CH_PLUS;
        in_plen = 2'd1;
      end else if (in_space) begin
        in_pfx0 = CH_BLANK;
        in_plen = 2'd1;
      end
    end
  end

  // shift-and-add-3 step
  always_comb begin
    logic [BCD_W-1:0] adj;
    adj = work;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (work[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = work[4*i +: 4] + 4'd3;
      end
    end
    bcd_next = {adj[BCD_W-2:0], sh[VALUE_W-1]};
  end

  always_comb begin
    dig = is_oct ? {1'b0, work[2:0]} : work[3:0];
    if (dig > 4'd9) begin
      dig_char = CH_ZERO + {4'd0, dig} + (upper ? HEX_UPPER_ADD : HEX_LOWER_ADD);
    end else begin
      dig_char = CH_ZERO + {4'd0, dig};
    end
    more = ((nd < prec) || (work != '0)) && (nd < NW'(MAX_CHARS));
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = nd[AW-1:0];
    ram_wdata = dig_char;
    if (state == S_DIGIT && more) begin
      ram_we = 1'b1;
    end else if (state == S_OCT && is_oct && last_nz && (nd < NW'(MAX_CHARS))) begin
      ram_we    = 1'b1;
      ram_wdata = CH_ZERO;
    end
  end

  // field layout: blanks, prefix, zeros, digits, right blanks
  always_comb begin
    used    = BW'(nd) + BW'(plen);
    pad     = (BW'(width_sat) > used) ? (BW'(width_sat) - used) : '0;
    lp      = (!left && !zpad) ? pad : '0;
    zp      = (zpad && !left) ? pad : '0;
    b1_n    = lp;
    b2_n    = lp + BW'(plen);
    b3_n    = b2_n + zp;
    b4_n    = b3_n + BW'(nd);
    sum_all = pad + used;
  end

  assign advance_out = !m_tvalid || m_tready;
  assign p1_move     = p1_v && advance_out;
  assign issue       = (state == S_EMIT) && (k < total) && (!p1_v || p1_move);
  assign rd_idx      = b4 - BW'(1) - k;

  always_comb begin
    sel_ram  = 1'b0;
    sel_char = CH_BLANK;
    if (k < b1) begin
      sel_char = CH_BLANK;
    end else if (k < b2) begin
      sel_char = (k == b1) ? pfx0 : pfx1;
    end else if (k < b3) begin
      sel_char = CH_ZERO;
    end else if (k < b4) begin
      sel_ram = 1'b1;
    end
  end

  ifmt_ram #(
    .WIDTH (8),
    .DEPTH (MAX_CHARS)
  ) u_digits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (rd_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && (in_conv <= CONV_OCT)) begin
            state <= (in_conv == CONV_SDEC || in_conv == CONV_UDEC) ? S_CONV : S_DIGIT;
          end
        end
        S_CONV: begin
          if (dd_cnt == 6'(VALUE_W - 1)) begin
            state <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          if (!more) begin
            state <= S_OCT;
          end
        end
        S_OCT:  state <= S_PLAN;
        S_PLAN: state <= S_EMIT;
        S_EMIT: begin
          if (k == total && !p1_v) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        is_oct    <= (in_conv == CONV_OCT);
        upper     <= in_upper;
        left      <= in_left;
        zpad      <= in_zpad && (in_prec == 6'd0);
        prec      <= in_prec_eff;
        width_sat <= in_width_eff;
        plen      <= in_plen;
        pfx0      <= in_pfx0;
        pfx1      <= in_pfx1;
        sh        <= in_masked;
        work      <= (in_conv == CONV_SDEC || in_conv == CONV_UDEC) ? '0 : BCD_W'(in_masked);
        dd_cnt    <= '0;
        nd        <= '0;
        last_nz   <= 1'b0;
      end
      S_CONV: begin
        work   <= bcd_next;
        sh     <= {sh[VALUE_W-2:0], 1'b0};
        dd_cnt <= dd_cnt + 6'd1;
      end
      S_DIGIT: begin
        if (more) begin
          work    <= is_oct ? (work >> 3) : (work >> 4);
          nd      <= nd + NW'(1);
          last_nz <= (dig != 4'd0);
        end
      end
      S_OCT: begin
        if (ram_we) begin
          nd <= nd + NW'(1);
        end
      end
      S_PLAN: begin
        b1    <= b1_n;
        b2    <= b2_n;
        b3    <= b3_n;
        b4    <= b4_n;
        total <= (sum_all > BW'(MAX_CHARS)) ? BW'(MAX_CHARS) : sum_all;
        k     <= '0;
      end
      S_EMIT: begin
        if (issue) begin
          k <= k + BW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // one character in flight while the memory read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
    end else if (issue) begin
      p1_v <= 1'b1;
    end else if (p1_move) begin
      p1_v <= 1'b0;
    end
    if (issue) begin
      p1_ram  <= sel_ram;
      p1_char <= sel_char;
      p1_last <= (k + BW'(1) == total);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance_out) begin
      m_tvalid <= p1_v;
    end
    if (advance_out && p1_v) begin
      m_tdata <= p1_ram ? ram_rdata : p1_char;
      m_tlast <= p1_last;
    end
  end

  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !p1_v)
    else $error("emit pipeline not drained when idle");

  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == S_DIGIT) || (state == S_OCT)))
    else $error("digit memory written outside digit phase");

  a_digit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_PLAN) |-> ((nd != '0) && (nd <= NW'(MAX_CHARS))))
    else $error("digit count out of range");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    issue |=> (k <= total))
    else $error("character index ran past field end");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (issue && p1_last && p1_v && p1_move) |-> 1'b0)
    else $error("character issued after the last one");

endmodule

`default_nettype wire
